// ===== rtl/core/mbp_pkg.sv =====
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the monochrome bitmap plot/replicate block.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int STORE_BYTES_DEF = 8192;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COORD_W   = 10;  // x_pos, y_pos, repeat_count
    localparam int OFFS_W    = 8;   // x_offset, y_offset
    localparam int CFG_W     = 11;  // line_width, line_count
    localparam int ADDR_IN_W = 13;  // byte_address field
    localparam int ROWS_W    = 10;  // duplicate row count
    localparam int RB_W      = 8;   // bytes per row
    localparam int PIX_W     = 22;  // linear pixel index
    localparam int DPTR_W    = 20;  // duplicate byte pointers
    localparam int IDX_IN_W  = 8;   // config register index

    localparam logic [IDX_IN_W-1:0] REG_LINE_WIDTH = 8'd0;
    localparam logic [IDX_IN_W-1:0] REG_LINE_COUNT = 8'd1;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 11'd256;
    localparam logic [CFG_W-1:0] LINE_COUNT_RST = 11'd64;

    typedef enum logic [1:0] {
        OP_PLOT = 2'd0,
        OP_DUP  = 2'd1,
        OP_READ = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CMD_PLOT,
        CMD_DUP,
        CMD_READ,
        CMD_FAIL
    } cmd_kind_t;

    // pos: pixel index for plot, source byte for duplicate, byte for read
    typedef struct packed {
        cmd_kind_t          kind;
        logic               value;
        logic [PIX_W-1:0]   pos;
        logic [ROWS_W-1:0]  rows;
    } cmd_t;

    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] line_count;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PLOT_WR,
        ST_READ_RD,
        ST_DUP,
        ST_DUP_TAIL,
        ST_DONE
    } bk_state_t;

endpackage

// ===== rtl/core/mbp_front.sv =====
// ----------------------------------------------------------------------------
// mbp_front
// Accepts transactions, clips and classifies them, forms the store index.
// ----------------------------------------------------------------------------
module mbp_front #(
    parameter int STORE_BYTES = mbp_pkg::STORE_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mbp_pkg::cfg_t cfg,
    input  logic          clear_busy,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output mbp_pkg::cmd_t q_cmd
);
    import mbp_pkg::*;

    logic                 accept;
    logic [COORD_W-1:0]   x_pos, y_pos, repeat_count;
    logic [OFFS_W-1:0]    x_offset, y_offset;
    logic                 pixel_value;
    logic [ADDR_IN_W-1:0] byte_address;
    op_t                  op;

    logic [CFG_W-1:0]     col, row, rows_avail;

    logic                 h_valid_reg, h_valid_next;
    cmd_kind_t            h_kind_reg, h_kind_next;
    logic                 h_value_reg;
    logic [CFG_W-1:0]     h_mul_a_reg, h_mul_a_next;
    logic [CFG_W-1:0]     h_mul_b_reg, h_mul_b_next;
    logic [ADDR_IN_W-1:0] h_add_reg, h_add_next;
    logic [ROWS_W-1:0]    h_rows_reg, h_rows_next;
    logic [PIX_W-1:0]     prod;

    assign x_pos        = s_tdata[9:0];
    assign y_pos        = s_tdata[19:10];
    assign x_offset     = s_tdata[27:20];
    assign y_offset     = s_tdata[35:28];
    assign pixel_value  = s_tdata[36];
    assign repeat_count = s_tdata[46:37];
    assign byte_address = s_tdata[59:47];
    assign op           = op_t'(s_tuser);

    assign q_push   = h_valid_reg && !q_full;
    assign s_tready = !clear_busy && (!h_valid_reg || !q_full);
    assign accept   = s_tvalid && s_tready;

    assign col        = {1'b0, x_pos} + {3'b000, x_offset};
    assign row        = {1'b0, y_pos} + {3'b000, y_offset};
    assign rows_avail = cfg.line_count - 11'd1 - {1'b0, y_pos};

    always_comb begin
        h_kind_next  = CMD_FAIL;
        h_mul_a_next = '0;
        h_mul_b_next = '0;
        h_add_next   = '0;
        h_rows_next  = '0;
        unique case (op)
            OP_PLOT: begin
                if ({1'b0, x_pos} >= cfg.line_width || {1'b0, y_pos} >= cfg.line_count ||
                    col >= cfg.line_width || row >= cfg.line_count) begin
                    h_kind_next = CMD_FAIL;
                end else begin
                    h_kind_next = CMD_PLOT;
                end
                h_mul_a_next = row;
                h_mul_b_next = cfg.line_width;
                h_add_next   = ADDR_IN_W'(col);
            end
            OP_DUP: begin
                h_kind_next  = ({1'b0, y_pos} >= cfg.line_count) ? CMD_FAIL : CMD_DUP;
                h_mul_a_next = {1'b0, y_pos};
                h_mul_b_next = {3'b000, cfg.line_width[CFG_W-1:3]};
                // clamp to rows that exist below the source
                h_rows_next  = ({1'b0, repeat_count} <= rows_avail) ? repeat_count
                                                                    : rows_avail[ROWS_W-1:0];
            end
            OP_READ: begin
                h_kind_next = (32'(byte_address) < 32'(STORE_BYTES)) ? CMD_READ : CMD_FAIL;
                h_add_next  = byte_address;
            end
            OP_RSVD: begin
                h_kind_next = CMD_FAIL;
            end
        endcase
    end

    always_comb begin
        h_valid_next = h_valid_reg;
        if (accept) begin
            h_valid_next = 1'b1;
        end else if (q_push) begin
            h_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_valid_reg <= 1'b0;
        end else begin
            h_valid_reg <= h_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            h_kind_reg  <= h_kind_next;
            h_value_reg <= pixel_value;
            h_mul_a_reg <= h_mul_a_next;
            h_mul_b_reg <= h_mul_b_next;
            h_add_reg   <= h_add_next;
            h_rows_reg  <= h_rows_next;
        end
    end

    assign prod = PIX_W'(h_mul_a_reg) * PIX_W'(h_mul_b_reg);

    assign q_cmd.kind  = h_kind_reg;
    assign q_cmd.value = h_value_reg;
    assign q_cmd.pos   = prod + PIX_W'(h_add_reg);
    assign q_cmd.rows  = h_rows_reg;

endmodule

// ===== rtl/core/mbp_queue.sv =====
// ----------------------------------------------------------------------------
// mbp_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module mbp_queue #(
    parameter int DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  mbp_pkg::cmd_t cmd_in,
    input  logic          pop,
    output mbp_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import mbp_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = entry[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

// ===== rtl/core/mbp_back.sv =====
// ----------------------------------------------------------------------------
// mbp_back
// Owns the pixel store: clear sweep, plot RMW, row copy, byte read, result.
// ----------------------------------------------------------------------------
module mbp_back #(
    parameter int STORE_BYTES = mbp_pkg::STORE_BYTES_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  mbp_pkg::cfg_t cfg,
    input  mbp_pkg::cmd_t head,
    input  logic          q_empty,
    output logic          q_pop,
    output logic          clear_busy,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata
);
    import mbp_pkg::*;

    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

    function automatic logic in_store(input logic [31:0] a);
        return a < 32'(STORE_BYTES);
    endfunction

    logic [7:0]        mem [STORE_BYTES];
    logic [7:0]        rd_data_reg;

    bk_state_t         state_reg, state_next;
    logic [ADDR_W-1:0] clr_ptr_reg, clr_ptr_next;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic [7:0]        mask_reg, mask_next;
    logic              value_reg, value_next;
    logic [DPTR_W-1:0] src_base_reg, src_base_next;
    logic [DPTR_W-1:0] dst_ptr_reg, dst_ptr_next;
    logic [RB_W-1:0]   j_reg, j_next;
    logic [ROWS_W-1:0] rows_left_reg, rows_left_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_status_reg, out_status_next;

    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [7:0]        wr_data;
    logic              fin, fin_status;
    logic [7:0]        fin_byte;
    logic              slot_free, ok, last_byte;
    logic [RB_W-1:0]   row_bytes;
    logic [PIX_W-4:0]  head_idx;
    logic [DPTR_W-1:0] src_ptr;

    assign slot_free  = !out_valid_reg || m_tready;
    assign row_bytes  = cfg.line_width[CFG_W-1:3];
    assign head_idx   = head.pos[PIX_W-1:3];
    assign src_ptr    = src_base_reg + DPTR_W'(j_reg);
    assign clear_busy = (state_reg == ST_CLEAR);

    always_comb begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        cur_addr_next   = cur_addr_reg;
        mask_next       = mask_reg;
        value_next      = value_reg;
        src_base_next   = src_base_reg;
        dst_ptr_next    = dst_ptr_reg;
        j_next          = j_reg;
        rows_left_next  = rows_left_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_byte_next   = res_byte_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        rd_en           = 1'b0;
        rd_addr         = cur_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = pend_addr_reg;
        wr_data         = rd_data_reg;
        fin             = 1'b0;
        fin_byte        = '0;
        fin_status      = 1'b0;
        q_pop           = 1'b0;
        ok              = 1'b0;
        last_byte       = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_ptr_reg;
                wr_data      = '0;
                clr_ptr_next = clr_ptr_reg + 1'b1;
                if (clr_ptr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    value_next = head.value;
                    mask_next  = 8'h80 >> head.pos[2:0];
                    unique case (head.kind)
                        CMD_PLOT: begin
                            if (in_store(32'(head_idx))) begin
                                rd_en         = 1'b1;
                                rd_addr       = ADDR_W'(head_idx);
                                cur_addr_next = ADDR_W'(head_idx);
                                state_next    = ST_PLOT_WR;
                            end else begin
                                fin        = 1'b1;
                                fin_status = 1'b1;
                            end
                        end
                        CMD_READ: begin
                            rd_en      = 1'b1;
                            rd_addr    = ADDR_W'(head.pos);
                            state_next = ST_READ_RD;
                        end
                        CMD_DUP: begin
                            if (head.rows == '0 || row_bytes == '0) begin
                                fin = 1'b1;
                            end else begin
                                src_base_next  = DPTR_W'(head.pos);
                                dst_ptr_next   = DPTR_W'(head.pos) + DPTR_W'(row_bytes);
                                j_next         = '0;
                                rows_left_next = head.rows;
                                state_next     = ST_DUP;
                            end
                        end
                        CMD_FAIL: begin
                            fin        = 1'b1;
                            fin_status = 1'b1;
                        end
                    endcase
                end
            end
            ST_PLOT_WR: begin
                wr_en   = 1'b1;
                wr_addr = cur_addr_reg;
                wr_data = value_reg ? (rd_data_reg | mask_reg) : (rd_data_reg & ~mask_reg);
                fin     = 1'b1;
            end
            ST_READ_RD: begin
                fin      = 1'b1;
                fin_byte = rd_data_reg;
            end
            ST_DUP: begin
                // read source byte now, write it in the next cycle
                wr_en           = pend_valid_reg;
                ok              = in_store(32'(src_ptr)) && in_store(32'(dst_ptr_reg));
                rd_en           = ok;
                rd_addr         = ADDR_W'(src_ptr);
                pend_valid_next = ok;
                pend_addr_next  = ADDR_W'(dst_ptr_reg);
                dst_ptr_next    = dst_ptr_reg + 1'b1;   // destination rows are contiguous
                last_byte       = (j_reg == row_bytes - 1'b1);
                if (last_byte) begin
                    j_next         = '0;
                    rows_left_next = rows_left_reg - 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                if ((last_byte && rows_left_reg == ROWS_W'(1)) ||
                    !in_store(32'(dst_ptr_reg))) begin
                    state_next = ST_DUP_TAIL;
                end
            end
            ST_DUP_TAIL: begin
                wr_en = pend_valid_reg;
                fin   = 1'b1;
            end
            ST_DONE: begin
                if (slot_free) begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = res_byte_reg;
                    out_status_next = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin) begin
            if (slot_free) begin
                out_valid_next  = 1'b1;
                out_byte_next   = fin_byte;
                out_status_next = fin_status;
                state_next      = ST_IDLE;
            end else begin
                res_byte_next   = fin_byte;
                res_status_next = fin_status;
                state_next      = ST_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_ptr_reg    <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_addr_reg   <= cur_addr_next;
        mask_reg       <= mask_next;
        value_reg      <= value_next;
        src_base_reg   <= src_base_next;
        dst_ptr_reg    <= dst_ptr_next;
        j_reg          <= j_next;
        rows_left_reg  <= rows_left_next;
        pend_addr_reg  <= pend_addr_next;
        res_byte_reg   <= res_byte_next;
        res_status_reg <= res_status_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_status_reg, out_byte_reg};

endmodule

// ===== rtl/core/mono_bitmap_plot_and_replicate_top.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_plot_and_replicate_top
// 1-bit-per-pixel label bitmap (MSB first) with plot, row duplicate and
// byte read-back.
// ----------------------------------------------------------------------------
//  channel | dir | ports                          | moves
//  --------+-----+--------------------------------+---------------------------
//  s_      | in  | s_tvalid s_tready s_tdata/user | one operation
//  m_      | out | m_tvalid m_tready m_tdata      | one result per operation
//  cfg_    | in  | cfg_valid cfg_ready index/data | one register write
//
//  In the back end a duplicate with no row to copy does not walk the store;
//  otherwise it walks each destination byte in turn (the walk ends at
//  the first destination byte past the store).
//  A transaction reaches the back end through the front register and
//  then the command queue.
//  Reset: after aresetn the store is cleared by a sweep of STORE_BYTES
//  cycles; s_tready stays low meanwhile, cfg writes are still taken.
//  Stalls: the front keeps accepting while the queue has room; a result
//  waiting on m_tready holds the back end only when the next one is ready.
// ----------------------------------------------------------------------------
module mono_bitmap_plot_and_replicate_top #(
    parameter int STORE_BYTES = mbp_pkg::STORE_BYTES_DEF,
    parameter int QUEUE_DEPTH = mbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mbp_pkg::IDX_IN_W-1:0]  cfg_index,
    input  logic [mbp_pkg::CFG_W-1:0]     cfg_data,
    // operations
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // x_pos[9:0] y_pos[19:10] x_offset[27:20] y_offset[35:28]
    // pixel_value[36] repeat_count[46:37] byte_address[59:47], zero pad
    input  logic [63:0]                   s_tdata,
    // operation[1:0]
    input  logic [1:0]                    s_tuser,
    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_byte[7:0] status[8], zero pad
    output logic [15:0]                   m_tdata
);
    import mbp_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t q_in, q_head;
    logic q_push, q_pop, q_full, q_empty;
    logic clear_busy;

    // the user must change config only while idle; the block does not enforce it and has no back-pressure
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_LINE_WIDTH) begin
                cfg_next.line_width = cfg_data;
            end else if (cfg_index == REG_LINE_COUNT) begin
                cfg_next.line_count = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.line_width <= LINE_WIDTH_RST;
            cfg_reg.line_count <= LINE_COUNT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mbp_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .clear_busy (clear_busy),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_in)
    );

    mbp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .cmd_in  (q_in),
        .pop     (q_pop),
        .head    (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    mbp_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // no transaction enters while the store is being cleared
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready)
        else $error("input accepted during store clear");

    // no result can exist before the clear sweep has finished
    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !m_tvalid)
        else $error("result presented during store clear");

    // a failed operation never returns store data
    a_fail_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[7:0] == 8'h00))
        else $error("failed result carries nonzero byte");

    // the back end only pops what the queue holds
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!q_empty && !clear_busy))
        else $error("queue popped while empty or clearing");

endmodule

// ===== test/mono_bitmap_plot_and_replicate_top_tb.sv =====
// ----------------------------------------------------------------------------
// mono_bitmap_plot_and_replicate_top_tb
// Self-checking bench for the label bitmap block: operations go in through
// a bursty stream driver, results are checked in order against a bitmap
// mirror kept in the bench, over several bitmap geometries.
// ----------------------------------------------------------------------------
module mono_bitmap_plot_and_replicate_top_tb;

    import mbp_pkg::*;

    localparam int STORE_BYTES  = STORE_BYTES_DEF;
    localparam int MAX_REPORTS  = 60;

    // one operation as it travels on s_tdata / s_tuser
    typedef struct {
        op_t         op;
        logic [9:0]  x_pos;
        logic [9:0]  y_pos;
        logic [7:0]  x_offset;
        logic [7:0]  y_offset;
        logic        pixel_value;
        logic [9:0]  repeat_count;
        logic [12:0] byte_address;
    } op_item_t;

    typedef struct {
        logic [7:0] read_byte;
        logic       status;
    } outcome_t;

    // receiver pacing styles
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } rdy_mode_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [10:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;

    // bench copy of the block state
    bit   [7:0]  label_bytes [STORE_BYTES];
    logic [10:0] cfg_width  = LINE_WIDTH_RST;
    logic [10:0] cfg_height = LINE_COUNT_RST;

    op_item_t    op_queue[$];
    outcome_t    predicted_outcomes[$];

    int unsigned items_queued   = 0;
    int unsigned items_taken    = 0;
    int unsigned results_checked = 0;
    int unsigned clipped_count  = 0;
    int unsigned settings_used  = 1;
    int unsigned mismatches     = 0;
    int unsigned cycle_count    = 0;
    int unsigned cycle_limit    = 40000;  // covers the clearing sweep after reset
    logic        op_hs          = 1'b0;   // s_ transaction at the last rising edge

    int unsigned gap_left   = 0;
    int unsigned burst_left = 0;
    int unsigned hold_left  = 0;
    int unsigned ready_tick = 0;
    rdy_mode_t   ready_mode = RDY_ALWAYS;

    mono_bitmap_plot_and_replicate_top #(
        .STORE_BYTES (STORE_BYTES)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // x_pos y_pos x_offset y_offset pixel_value repeat_count byte_address
        .s_tdata   (s_tdata),
        // operation
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // read_byte status
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Mismatch reporting: count everything, print a bounded number of lines.
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (mismatches < MAX_REPORTS)
            $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h",
                     results_checked, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Bitmap predictor: applies one accepted operation to the mirror and
    // queues the result the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic void apply_to_bitmap(input op_t op,
                                            input logic [9:0] x_in, y_in,
                                            input logic [7:0] xo_in, yo_in,
                                            input logic v,
                                            input logic [9:0] rep_in,
                                            input logic [12:0] addr_in);
        int unsigned w, h, x, y, col, row, pix, idx, rep, row_bytes, src, dst;
        logic [7:0]  bit_mask;
        outcome_t    res;
        w = cfg_width;
        h = cfg_height;
        x = x_in;
        y = y_in;
        rep = rep_in;
        res.read_byte = 8'h00;
        res.status    = 1'b1;
        case (op)
            OP_PLOT: begin
                col = x + xo_in;
                row = y + yo_in;
                pix = row * w + col;
                idx = pix >> 3;
                // origin, row and bitmap clipping, then the store bound
                if (x < w && y < h && col < w && row < h && idx < STORE_BYTES) begin
                    bit_mask = 8'h80 >> (pix & 7);
                    if (v)
                        label_bytes[idx] = label_bytes[idx] | bit_mask;
                    else
                        label_bytes[idx] = label_bytes[idx] & ~bit_mask;
                    res.status = 1'b0;
                end
            end
            OP_DUP: begin
                if (y < h) begin
                    row_bytes = w / 8;
                    src = y * row_bytes;
                    for (int unsigned i = 1; i <= rep; i++) begin
                        if (y + i >= h)
                            break;
                        dst = src + i * row_bytes;
                        for (int unsigned j = 0; j < row_bytes; j++)
                            if (src + j < STORE_BYTES && dst + j < STORE_BYTES)
                                label_bytes[dst + j] = label_bytes[src + j];
                    end
                    res.status = 1'b0;
                end
            end
            OP_READ: begin
                if (addr_in < STORE_BYTES) begin
                    res.read_byte = label_bytes[addr_in];
                    res.status    = 1'b0;
                end
            end
            default: ;  // reserved code: no change, flagged
        endcase
        if (res.status)
            clipped_count++;
        predicted_outcomes.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: rising edge. Input transactions feed the predictor, output
    // transactions are checked against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch_ports
        outcome_t want;
        if (!aresetn) begin
            op_hs <= 1'b0;
        end else begin
            cycle_count++;
            op_hs <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                apply_to_bitmap(op_t'(s_tuser), s_tdata[9:0], s_tdata[19:10],
                                s_tdata[27:20], s_tdata[35:28], s_tdata[36],
                                s_tdata[46:37], s_tdata[59:47]);
                items_taken++;
            end
            if (m_tvalid && m_tready) begin
                if (predicted_outcomes.size() == 0) begin
                    flag_mismatch("with no operation pending", m_tdata, 0);
                end else begin
                    want = predicted_outcomes.pop_front();
                    if (m_tdata[7:0] !== want.read_byte)
                        flag_mismatch("read_byte", m_tdata[7:0], want.read_byte);
                    if (m_tdata[8] !== want.status)
                        flag_mismatch("status", m_tdata[8], want.status);
                end
                results_checked++;
            end
            if (cycle_count > cycle_limit) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Operation driver: falling edge. Bursts of random length separated by
    // random gaps; a long burst now and then gives stretches with no idling.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : feed_ops
        op_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || op_hs) begin
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (op_queue.size() != 0) begin
                nxt = op_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {4'b0, nxt.byte_address, nxt.repeat_count, nxt.pixel_value,
                             nxt.y_offset, nxt.x_offset, nxt.y_pos, nxt.x_pos};
                s_tuser  <= nxt.op;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                             : $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: falling edge. Pacing style is redrawn at random; the
    // periodic style holds m_tready high only in the first quarter of each period.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : pace_results
        if (hold_left == 0) begin
            ready_mode = rdy_mode_t'($urandom_range(0, 3));
            hold_left  = $urandom_range(40, 400);
        end else begin
            hold_left--;
        end
        ready_tick++;
        case (ready_mode)
            RDY_ALWAYS: m_tready <= 1'b1;
            RDY_COIN:   m_tready <= $urandom_range(0, 1);
            RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
            default:    m_tready <= ((ready_tick % 24) < 6);
        endcase
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_op(input op_t op, input int unsigned x, y, xo, yo, v, rep,
                           input int unsigned addr);
        op_item_t it;
        int unsigned walk;
        it.op           = op;
        it.x_pos        = x[9:0];
        it.y_pos        = y[9:0];
        it.x_offset     = xo[7:0];
        it.y_offset     = yo[7:0];
        it.pixel_value  = v[0];
        it.repeat_count = rep[9:0];
        it.byte_address = addr[12:0];
        // a duplicate may walk every byte of every row it is asked for
        walk = (op == OP_DUP) ? it.repeat_count * (cfg_width / 8) + 8 : 0;
        cycle_limit += 4 * (64 + walk);
        op_queue.push_back(it);
        items_queued++;
    endtask

    // wait until every accepted operation has its result back, then settle
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (items_taken != items_queued || predicted_outcomes.size() != 0);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_register(input logic [7:0] idx, input logic [10:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_LINE_WIDTH)
            cfg_width = val;
        else if (idx == REG_LINE_COUNT)
            cfg_height = val;
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h);
        wait_idle();
        write_register(REG_LINE_WIDTH, w[10:0]);
        write_register(REG_LINE_COUNT, h[10:0]);
        settings_used++;
    endtask

    // Random operations shaped for the current geometry: most plots land
    // inside the bitmap and the store, most reads hit the bitmap bytes,
    // duplicates mostly use short repeat counts to keep the walk short.
    task automatic push_random(input int n);
        int unsigned w, h, sel, x, y, xo, yo, v, rep, addr, c, r, rows_in, bytes;
        op_t op;
        repeat (n) begin
            w    = cfg_width;
            h    = cfg_height;
            sel  = $urandom_range(0, 99);
            op   = (sel < 45) ? OP_PLOT : (sel < 60) ? OP_DUP : (sel < 96) ? OP_READ
                                                                            : OP_RSVD;
            x    = $urandom_range(0, 1023);
            y    = $urandom_range(0, 1023);
            xo   = $urandom_range(0, 255);
            yo   = $urandom_range(0, 255);
            v    = ($urandom_range(0, 9) < 7);
            rep  = $urandom_range(0, 1023);
            addr = $urandom_range(0, STORE_BYTES - 1);
            case (op)
                OP_PLOT: begin
                    if ($urandom_range(0, 9) < 8 && w > 0 && h > 0) begin
                        c  = $urandom_range(0, w - 1);
                        xo = $urandom_range(0, (c < 255) ? c : 255);
                        x  = c - xo;
                        rows_in = (STORE_BYTES * 8 / w < h) ? STORE_BYTES * 8 / w : h;
                        r  = $urandom_range(0, rows_in - 1);
                        yo = $urandom_range(0, (r < 255) ? r : 255);
                        y  = r - yo;
                    end
                end
                OP_DUP: begin
                    if ($urandom_range(0, 99) < 85 && h > 0)
                        y = $urandom_range(0, h - 1);
                    sel = $urandom_range(0, 99);
                    if (sel < 85) begin
                        rep = $urandom_range(0, 6);
                    end else if (sel < 97) begin
                        rep = $urandom_range(0, 24);
                    end else if (h > 0) begin
                        // long repeat near the bottom: walk stays short
                        y = (h > 4) ? h - 1 - $urandom_range(0, 3) : 0;
                    end
                end
                OP_READ: begin
                    bytes = (w * h + 7) / 8;
                    if (bytes > STORE_BYTES)
                        bytes = STORE_BYTES;
                    if ($urandom_range(0, 3) != 0 && bytes > 0)
                        addr = $urandom_range(0, bytes - 1);
                end
                default: ;
            endcase
            push_op(op, x, y, xo, yo, v, rep, addr);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed, reset geometry 256 x 64 on a blank store
        push_op(OP_PLOT, 0, 0, 0, 0, 1, 0, 0);              // top-left corner
        push_op(OP_PLOT, 0, 0, 255, 63, 1, 0, 0);           // bottom-right via offsets
        push_op(OP_PLOT, 1, 0, 255, 0, 1, 0, 0);            // leaves the row
        push_op(OP_PLOT, 0, 1, 0, 63, 1, 0, 0);             // below the bitmap
        push_op(OP_PLOT, 256, 0, 0, 0, 1, 0, 0);            // origin right of bitmap
        push_op(OP_PLOT, 0, 64, 0, 0, 1, 0, 0);             // origin below bitmap
        push_op(OP_PLOT, 1023, 1023, 255, 255, 1, 1023, 8191);
        push_op(OP_PLOT, 7, 0, 0, 0, 1, 0, 0);              // LSB of byte 0
        push_op(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        push_op(OP_READ, 0, 0, 0, 0, 0, 0, 2047);
        push_op(OP_PLOT, 0, 0, 0, 0, 0, 0, 0);              // clear a set pixel
        push_op(OP_DUP, 0, 0, 0, 0, 0, 3, 0);
        push_op(OP_READ, 0, 0, 0, 0, 0, 0, 32);
        push_op(OP_DUP, 0, 63, 0, 0, 0, 5, 0);              // all targets past height
        push_op(OP_DUP, 0, 64, 0, 0, 0, 1, 0);              // source row outside
        push_op(OP_DUP, 0, 0, 0, 0, 0, 0, 0);               // zero repeat
        push_op(OP_RSVD, 1023, 1023, 255, 255, 1, 1023, 8191);
        push_op(OP_READ, 0, 0, 0, 0, 0, 0, 8191);
        push_op(OP_RSVD, 0, 0, 0, 0, 0, 0, 0);
        push_random(150);

        set_geometry(8, 1);                 // smallest bitmap with a whole byte row
        push_random(90);

        // largest geometry: most of it lies beyond the store
        set_geometry(1024, 1024);
        push_op(OP_PLOT, 0, 64, 0, 0, 1, 0, 0);             // first byte past the store
        push_op(OP_PLOT, 1023, 63, 0, 0, 1, 0, 0);          // last store byte
        push_op(OP_DUP, 0, 0, 0, 0, 0, 100, 0);             // targets run off the store
        push_op(OP_DUP, 0, 70, 0, 0, 0, 3, 0);              // source past the store
        push_op(OP_READ, 0, 0, 0, 0, 0, 0, 8191);
        push_random(110);

        set_geometry(100, 50);              // width not a whole number of bytes
        push_random(110);
        set_geometry(0, 10);                // zero width
        push_random(50);
        set_geometry(64, 0);                // zero height
        push_random(50);
        set_geometry(1024, 1);
        push_random(80);
        set_geometry(8, 1024);
        push_random(110);
        set_geometry(LINE_WIDTH_RST, LINE_COUNT_RST);
        push_random(90);
        repeat (5) begin
            set_geometry(8 * $urandom_range(1, 128), $urandom_range(1, 1024));
            push_random(100);
        end

        wait_idle();
        repeat (40) @(negedge aclk);

        $display("Ran %0d operations over %0d bitmap geometries: %0d results checked, %0d clipped or rejected",
                 items_taken, settings_used, results_checked, clipped_count);
        if (mismatches == 0 && predicted_outcomes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
